// File: rtl/core/dtip_pkg.sv
// Shared types, codes and constants for the debounced trigger input port
`timescale 1ns / 1ps

package dtip_pkg;

  // field widths
  localparam int TIME_W   = 48;
  localparam int WINDOW_W = 20;
  localparam int PORT_W   = 8;
  localparam int NUM_TRIG = 4;
  localparam int BIT_W    = $clog2(PORT_W);
  localparam int REG_W    = 2;

  // trigger line positions on the port
  localparam logic [BIT_W-1:0] TRIG1_A_BIT = 3'd3;
  localparam logic [BIT_W-1:0] TRIG1_B_BIT = 3'd4;
  localparam logic [BIT_W-1:0] TRIG2_A_BIT = 3'd5;
  localparam logic [BIT_W-1:0] TRIG2_B_BIT = 3'd6;
  localparam logic [BIT_W-1:0] TRIG_BITS [NUM_TRIG] =
    '{TRIG1_A_BIT, TRIG1_B_BIT, TRIG2_A_BIT, TRIG2_B_BIT};

  // command codes
  localparam logic [2:0] CMD_NOTICE    = 3'd0;
  localparam logic [2:0] CMD_PROCESS   = 3'd1;
  localparam logic [2:0] CMD_CLEAR     = 3'd2;
  localparam logic [2:0] CMD_SET_LINE  = 3'd3;
  localparam logic [2:0] CMD_RESET_ACC = 3'd4;

  // register indexes
  localparam logic [REG_W-1:0] REG_WINDOW   = 2'd0;
  localparam logic [REG_W-1:0] REG_ACC_MASK = 2'd1;

  // reset values
  localparam logic [WINDOW_W-1:0] WINDOW_RST   = 20'd50000;
  localparam logic [PORT_W-1:0]   ACC_MASK_RST = 8'h07;
  localparam logic [PORT_W-1:0]   ALL_HIGH     = 8'hFF;

  typedef struct packed {
    logic [2:0]        command;
    logic [TIME_W-1:0] now_us;
    logic [PORT_W-1:0] port_sample;
    logic              read_ok;
    logic              rescan;
    logic [BIT_W-1:0]  line_bit;
    logic              line_level;
  } item_t;

  typedef struct packed {
    logic [NUM_TRIG-1:0] trigger_event_mask;
    logic [NUM_TRIG-1:0] trigger_active_levels;
    logic [1:0]          led_one_colour;
    logic [1:0]          led_two_colour;
    logic                read_error;
    logic [PORT_W-1:0]   port_levels;
    logic                write_valid;
    logic [PORT_W-1:0]   write_value;
  } result_t;

  typedef struct packed {
    logic [REG_W-1:0]    index;
    logic [WINDOW_W-1:0] value;
  } cfg_t;

  // led colour: bit 0 line A pressed, bit 1 line B pressed (active low)
  function automatic logic [1:0] led_colour(input logic [PORT_W-1:0] levels,
                                            input logic [BIT_W-1:0] bit_a,
                                            input logic [BIT_W-1:0] bit_b);
    return {~levels[bit_b], ~levels[bit_a]};
  endfunction

endpackage

// File: rtl/core/dtip_stream_if.sv
// Valid/ready channel carrying one payload struct
`timescale 1ns / 1ps

interface dtip_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/debounced_trigger_input_port.sv
// Top level: debounced trigger input port with registered result
// latency: one result per item, valid in the cycle after the input transfer
// throughput: one item per cycle while the result side takes every result
// the result register frees in the same cycle it is taken, so a new item enters then
// rst (synchronous) restores the configuration, state and result valid registers; result data is not reset
`timescale 1ns / 1ps

module debounced_trigger_input_port (
  input  logic          clk,
  input  logic          rst,
  dtip_stream_if.sink   item,
  dtip_stream_if.source result,
  dtip_stream_if.sink   cfg
);

  // configuration registers
  logic [dtip_pkg::WINDOW_W-1:0] window;
  logic [dtip_pkg::PORT_W-1:0]   acc_mask;

  // block state
  logic                          pending;
  logic [dtip_pkg::PORT_W-1:0]   last_port;
  logic [dtip_pkg::PORT_W-1:0]   accepted;
  logic [dtip_pkg::TIME_W-1:0]   change_time [dtip_pkg::NUM_TRIG];
  logic [dtip_pkg::TIME_W-1:0]   deadline;
  logic [dtip_pkg::PORT_W-1:0]   out_mask;

  logic                          pending_next;
  logic [dtip_pkg::PORT_W-1:0]   last_port_next;
  logic [dtip_pkg::PORT_W-1:0]   accepted_next;
  logic [dtip_pkg::TIME_W-1:0]   change_time_next [dtip_pkg::NUM_TRIG];
  logic [dtip_pkg::TIME_W-1:0]   deadline_next;
  logic [dtip_pkg::PORT_W-1:0]   out_mask_next;

  // result register
  logic                          out_valid;
  dtip_pkg::result_t             out_data;
  dtip_pkg::result_t             result_next;

  dtip_pkg::item_t               d;
  logic                          item_xfer;
  logic [dtip_pkg::TIME_W-1:0]   window_ext;
  logic [dtip_pkg::TIME_W-1:0]   new_deadline;
  logic                          recheck_due;
  logic [dtip_pkg::NUM_TRIG-1:0] too_soon;

  assign d          = item.data;
  assign item.ready = !out_valid || result.ready;
  assign item_xfer  = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // per-line debounce window checks, all in parallel
  assign window_ext   = dtip_pkg::TIME_W'(window);
  assign new_deadline = d.now_us + window_ext;
  assign recheck_due  = (deadline != '0) && (d.now_us > deadline);

  always_comb begin
    for (int i = 0; i < dtip_pkg::NUM_TRIG; i++) begin
      too_soon[i] = (d.now_us - change_time[i]) < window_ext;
    end
  end

  // next state and result for the item on the input
  always_comb begin
    logic                          force_eff;
    logic [dtip_pkg::BIT_W-1:0]    b;
    logic [dtip_pkg::NUM_TRIG-1:0] events;
    logic [dtip_pkg::NUM_TRIG-1:0] actives;
    logic                          rd_err;
    logic                          wr_valid;

    pending_next   = pending;
    last_port_next = last_port;
    accepted_next  = accepted;
    change_time_next = change_time;
    deadline_next  = deadline;
    out_mask_next  = out_mask;
    force_eff      = d.rescan;
    b              = '0;
    events         = '0;
    actives        = '0;
    rd_err         = 1'b0;
    wr_valid       = 1'b0;

    case (d.command)
      dtip_pkg::CMD_NOTICE: begin
        pending_next = 1'b1;
      end
      dtip_pkg::CMD_PROCESS: begin
        if (recheck_due) begin
          force_eff     = 1'b1;
          deadline_next = '0;
        end
        if (pending || force_eff) begin
          pending_next = 1'b0;
          if (!d.read_ok) begin
            pending_next = 1'b1;
            rd_err       = 1'b1;
          end else if ((d.port_sample != last_port) || force_eff) begin
            last_port_next = d.port_sample;
            // triggers in order 1A, 1B, 2A, 2B; each sees earlier updates
            for (int i = 0; i < dtip_pkg::NUM_TRIG; i++) begin
              b = dtip_pkg::TRIG_BITS[i];
              if (accepted_next[b] != d.port_sample[b]) begin
                change_time_next[i] = d.now_us;
                if (too_soon[i]) begin
                  deadline_next = new_deadline;
                end else begin
                  accepted_next[b] = d.port_sample[b];
                  events[i]        = 1'b1;
                  actives[i]       = ~d.port_sample[b];
                end
              end
            end
          end
        end
      end
      dtip_pkg::CMD_CLEAR: begin
        if (d.read_ok) begin
          last_port_next = d.port_sample;
        end else begin
          rd_err = 1'b1;
        end
        accepted_next = last_port_next;
      end
      dtip_pkg::CMD_SET_LINE: begin
        if (acc_mask[d.line_bit]) begin
          out_mask_next[d.line_bit] = d.line_level;
          wr_valid                  = 1'b1;
        end
      end
      dtip_pkg::CMD_RESET_ACC: begin
        out_mask_next = dtip_pkg::ALL_HIGH;
        wr_valid      = 1'b1;
      end
      default: begin
      end
    endcase

    result_next.trigger_event_mask    = events;
    result_next.trigger_active_levels = actives;
    result_next.led_one_colour        = dtip_pkg::led_colour(last_port_next,
                                          dtip_pkg::TRIG1_A_BIT, dtip_pkg::TRIG1_B_BIT);
    result_next.led_two_colour        = dtip_pkg::led_colour(last_port_next,
                                          dtip_pkg::TRIG2_A_BIT, dtip_pkg::TRIG2_B_BIT);
    result_next.read_error            = rd_err;
    result_next.port_levels           = last_port_next;
    result_next.write_valid           = wr_valid;
    result_next.write_value           = out_mask_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= dtip_pkg::WINDOW_RST;
      acc_mask <= dtip_pkg::ACC_MASK_RST;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        dtip_pkg::REG_WINDOW:   window   <= cfg.data.value;
        dtip_pkg::REG_ACC_MASK: acc_mask <= cfg.data.value[dtip_pkg::PORT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // state update on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      last_port <= '0;
      accepted  <= '0;
      deadline  <= '0;
      out_mask  <= dtip_pkg::ALL_HIGH;
      for (int i = 0; i < dtip_pkg::NUM_TRIG; i++) begin
        change_time[i] <= '0;
      end
    end else if (item_xfer) begin
      pending     <= pending_next;
      last_port   <= last_port_next;
      accepted    <= accepted_next;
      deadline    <= deadline_next;
      out_mask    <= out_mask_next;
      change_time <= change_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_xfer) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      out_data <= result_next;
    end
  end

endmodule

// File: rtl/core/dtip_checker.sv
// Port-level assertions for the debounced trigger input port, bound to the top level
`timescale 1ns / 1ps

module dtip_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic [2:0]        item_command,
  input logic              res_valid,
  input logic              res_ready,
  input dtip_pkg::result_t res_data
);

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // every input transfer yields a result in the next cycle
  a_res_follows: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> res_valid)
    else $error("no result after input transfer");

  // a stalled result blocks new input
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !item_ready)
    else $error("input taken while result stalled");

  // accessory port reset drives all lines high
  a_acc_reset: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item_command == dtip_pkg::CMD_RESET_ACC) |=>
      res_data.write_valid && (res_data.write_value == dtip_pkg::ALL_HIGH))
    else $error("accessory reset not reported");

  // led colours follow the reported port levels
  a_led_levels: assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      (res_data.led_one_colour == dtip_pkg::led_colour(res_data.port_levels,
         dtip_pkg::TRIG1_A_BIT, dtip_pkg::TRIG1_B_BIT)) &&
      (res_data.led_two_colour == dtip_pkg::led_colour(res_data.port_levels,
         dtip_pkg::TRIG2_A_BIT, dtip_pkg::TRIG2_B_BIT)))
    else $error("led colour does not match port levels");

endmodule

bind debounced_trigger_input_port dtip_checker u_dtip_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_command (item.data.command),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_data     (result.data)
);
